FILE: hdl/xxtea_block_cipher_unit_defines.svh
// assertion macros for the xxtea block cipher unit
// included by the checker; needs no other file
`ifndef XXTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define XXTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define XBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define XBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/xbc_pkg.sv
// shared types, constants and cipher functions of the xxtea block cipher unit
// no dependencies
`timescale 1ns / 1ps

package xbc_pkg;

    localparam int MAX_WORDS  = 16;
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int ROUND_BASE = 6;
    localparam int ROUND_SPAN = 52;
    localparam int ROUND_W    = $clog2(ROUND_BASE + ROUND_SPAN + 1);
    localparam int KEY_WORDS  = 4;
    localparam int PADDR_W    = 4;

    localparam logic [WORD_W-1:0] CIPHER_DELTA = 32'h9E37_79B9;

    // register indexes of the configuration port
    localparam logic [1:0] REG_KEY_0 = 2'd0;
    localparam logic [1:0] REG_KEY_1 = 2'd1;
    localparam logic [1:0] REG_KEY_2 = 2'd2;
    localparam logic [1:0] REG_KEY_3 = 2'd3;

    typedef logic [WORD_W-1:0]                 word_t;
    typedef logic [ADDR_W-1:0]                 addr_t;
    typedef logic [CNT_W-1:0]                  cnt_t;
    typedef logic [ROUND_W-1:0]                round_t;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0]  key_t;

    typedef struct packed {
        round_t rounds;
        word_t  dec_sum;
    } plan_t;

    // round count 6 + 52/n and the starting sum for decryption, per block size
    function automatic plan_t cipher_plan(input cnt_t n);
        plan_t  plan;
        round_t q;
        plan.rounds  = '0;
        plan.dec_sum = '0;
        for (int i = 1; i <= MAX_WORDS; i++) begin
            q = round_t'(ROUND_BASE);
            for (int j = 1; j <= ROUND_SPAN; j++) begin
                if (j * i <= ROUND_SPAN) begin
                    q = round_t'(q + 1'b1);
                end
            end
            if (n == cnt_t'(i)) begin
                plan.rounds  = q;
                plan.dec_sum = word_t'(word_t'(q) * CIPHER_DELTA);
            end
        end
        return plan;
    endfunction

    // xxtea mixing function, key word already selected
    function automatic word_t mix_word(input word_t z, input word_t y,
                                       input word_t sum, input word_t key_word);
        word_t a;
        word_t b;
        word_t c;
        a = (z >> 5) ^ (y << 2);
        b = (y >> 3) ^ (z << 4);
        c = (sum ^ y) + (key_word ^ z);
        return (a + b) ^ c;
    endfunction

endpackage

FILE: hdl/xbc_word_if.sv
// input stream interface: one block word per transfer
// depends on xbc_pkg
`timescale 1ns / 1ps

interface xbc_word_if import xbc_pkg::*; ();

    logic  valid;
    logic  ready;
    logic  func;
    word_t data_word;
    logic  block_end;

    modport source (output valid, func, data_word, block_end, input ready);
    modport sink   (input valid, func, data_word, block_end, output ready);

endinterface

FILE: hdl/xbc_result_if.sv
// output stream interface: one result word per transfer
// depends on xbc_pkg
`timescale 1ns / 1ps

interface xbc_result_if import xbc_pkg::*; ();

    logic  valid;
    logic  ready;
    word_t result_word;
    logic  result_last;

    modport source (output valid, result_word, result_last, input ready);
    modport sink   (input valid, result_word, result_last, output ready);

endinterface

FILE: hdl/xbc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module xbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read; a read of the address written at the same edge sees old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/xbc_key_regs.sv
// key register file behind the apb-style configuration port
// depends on xbc_pkg
`timescale 1ns / 1ps

module xbc_key_regs import xbc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  word_t              pwdata,
    output word_t              prdata,
    output logic               pready,
    output key_t               key
);

    key_t       key_reg;
    key_t       key_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign key     = key_reg;

    // register write decode
    always_comb
    begin
        key_next = key_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_KEY_0: key_next[0] = pwdata;
                REG_KEY_1: key_next[1] = pwdata;
                REG_KEY_2: key_next[2] = pwdata;
                REG_KEY_3: key_next[3] = pwdata;
                default:   key_next = key_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_KEY_0: prdata = key_reg[0];
            REG_KEY_1: prdata = key_reg[1];
            REG_KEY_2: prdata = key_reg[2];
            REG_KEY_3: prdata = key_reg[3];
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

endmodule

FILE: hdl/xxtea_block_cipher_unit.sv
// xxtea block cipher unit: top level; uses xbc_pkg, xbc_word_if, xbc_result_if, xbc_ram, xbc_key_regs
// an n-word block is loaded word by word, set up in ST_PRE0, ST_PRE1 and ST_PRE2, mixed in ST_RUN,
// then read out one result word at a time while the sink is ready
// throughput: one mixing step per cycle, bounded by the single read port of the word store
// and the z/y dependency through the mixing adders; blocks are processed one at a time
// reset: control state and key registers clear asynchronously; the word store is not cleared
`timescale 1ns / 1ps

module xxtea_block_cipher_unit import xbc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  word_t              pwdata,
    output word_t              prdata,
    output logic               pready,
    xbc_word_if.sink           word_stream,
    xbc_result_if.source       result_stream
);

    // sequencer codes
    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_PRE0 = 3'd1;
    localparam logic [2:0] ST_PRE1 = 3'd2;
    localparam logic [2:0] ST_PRE2 = 3'd3;
    localparam logic [2:0] ST_RUN  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    function automatic addr_t wrap_inc(input addr_t a, input addr_t last);
        return (a == last) ? '0 : addr_t'(a + 1'b1);
    endfunction

    function automatic addr_t wrap_dec(input addr_t a, input addr_t last);
        return (a == '0) ? last : addr_t'(a - 1'b1);
    endfunction

    // control registers
    logic [2:0] state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    logic       mode_reg, mode_next;
    round_t     rounds_reg, rounds_next;
    addr_t      p_reg, p_next;
    addr_t      f_reg, f_next;
    logic       fwd_reg, fwd_next;
    addr_t      k_reg, k_next;
    logic       pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;

    // payload registers
    cnt_t       n_reg, n_next;
    word_t      sum_reg, sum_next;
    word_t      z_reg, z_next;
    word_t      y_reg, y_next;
    word_t      cur_reg, cur_next;
    logic       pend_last_reg, pend_last_next;
    word_t      out_word_reg, out_word_next;
    logic       out_last_reg, out_last_next;

    // store ports
    logic       ram_we;
    addr_t      ram_waddr;
    word_t      ram_wdata;
    addr_t      ram_raddr;
    word_t      ram_rdata;

    key_t       key;
    cnt_t       n_minus_1;
    addr_t      last_addr;
    logic [ADDR_W:0] p_ext;
    logic [1:0] key_idx;
    word_t      key_word;
    word_t      fetched;
    word_t      mix_z;
    word_t      mix_y;
    word_t      mixed;
    word_t      step_word;
    addr_t      p_adv;
    addr_t      f_adv;
    logic       round_end;
    logic       in_xfer;
    logic       issue_ok;
    plan_t      plan;

    xbc_key_regs u_keys (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key     (key)
    );

    xbc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // stream handshakes
    assign word_stream.ready         = (state_reg == ST_LOAD);
    assign in_xfer                   = word_stream.valid && word_stream.ready;
    assign result_stream.valid       = out_valid_reg;
    assign result_stream.result_word = out_word_reg;
    assign result_stream.result_last = out_last_reg;

    // block geometry
    assign n_minus_1 = n_reg - cnt_t'(1);
    assign last_addr = n_minus_1[ADDR_W-1:0];
    assign plan      = cipher_plan(n_reg);

    // key word selection: (p & 3) ^ e
    assign p_ext    = {1'b0, p_reg};
    assign key_idx  = p_ext[1:0] ^ sum_reg[3:2];
    assign key_word = key[key_idx];

    // fetched word, forwarded when the store was written at the edge it was read
    assign fetched = fwd_reg ? (mode_reg ? y_reg : z_reg) : ram_rdata;

    // one mixing step: encrypt adds into store[p], decrypt subtracts
    assign mix_z     = mode_reg ? fetched : z_reg;
    assign mix_y     = mode_reg ? y_reg : fetched;
    assign mixed     = mix_word(mix_z, mix_y, sum_reg, key_word);
    assign step_word = mode_reg ? (cur_reg - mixed) : (cur_reg + mixed);

    // position walk: upward for encrypt, downward for decrypt
    assign p_adv     = mode_reg ? wrap_dec(p_reg, last_addr) : wrap_inc(p_reg, last_addr);
    assign f_adv     = mode_reg ? wrap_dec(f_reg, last_addr) : wrap_inc(f_reg, last_addr);
    assign round_end = mode_reg ? (p_reg == '0) : (p_reg == last_addr);

    // result slot free at the coming edge
    assign issue_ok = !pend_reg && (!out_valid_reg || result_stream.ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        rounds_next    = rounds_reg;
        p_next         = p_reg;
        f_next         = f_reg;
        fwd_next       = fwd_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        n_next         = n_reg;
        sum_next       = sum_reg;
        z_next         = z_reg;
        y_next         = y_reg;
        cur_next       = cur_reg;
        pend_last_next = pend_last_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        // result register: drain on transfer, fill from a pending store read
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            out_word_next  = ram_rdata;
            out_last_next  = pend_last_reg;
            pend_next      = 1'b0;
        end
        else if (result_stream.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[ADDR_W-1:0];
                    ram_wdata = word_stream.data_word;
                    if (cnt_reg == '0)
                    begin
                        mode_next = word_stream.func;
                    end
                    if (word_stream.block_end || (cnt_reg == cnt_t'(MAX_WORDS - 1)))
                    begin
                        n_next     = cnt_t'(cnt_reg + 1'b1);
                        cnt_next   = '0;
                        state_next = ST_PRE0;
                    end
                    else
                    begin
                        cnt_next = cnt_t'(cnt_reg + 1'b1);
                    end
                end
            end

            // read z (encrypt) or y (decrypt) and set up the round counter
            ST_PRE0:
            begin
                rounds_next = plan.rounds;
                sum_next    = mode_reg ? plan.dec_sum : CIPHER_DELTA;
                ram_raddr   = mode_reg ? '0 : last_addr;
                state_next  = ST_PRE1;
            end

            // capture the link word, read the first word to modify
            ST_PRE1:
            begin
                if (mode_reg)
                begin
                    y_next = ram_rdata;
                end
                else
                begin
                    z_next = ram_rdata;
                end
                ram_raddr  = mode_reg ? last_addr : '0;
                state_next = ST_PRE2;
            end

            // capture the first word, fetch the neighbor of the first step
            ST_PRE2:
            begin
                cur_next   = ram_rdata;
                p_next     = mode_reg ? last_addr : '0;
                f_next     = mode_reg ? wrap_dec(last_addr, last_addr)
                                      : wrap_inc('0, last_addr);
                ram_raddr  = f_next;
                fwd_next   = 1'b0;
                state_next = ST_RUN;
            end

            // one mixing step per cycle, read of the next neighbor overlapped
            ST_RUN:
            begin
                ram_we    = 1'b1;
                ram_waddr = p_reg;
                ram_wdata = step_word;
                if (mode_reg)
                begin
                    y_next = step_word;
                end
                else
                begin
                    z_next = step_word;
                end
                // a one-word block modifies the same word again next step
                cur_next  = (p_adv == p_reg) ? step_word : fetched;
                p_next    = p_adv;
                f_next    = f_adv;
                ram_raddr = f_adv;
                fwd_next  = (f_adv == p_reg);
                if (round_end)
                begin
                    sum_next    = mode_reg ? (sum_reg - CIPHER_DELTA) : (sum_reg + CIPHER_DELTA);
                    rounds_next = round_t'(rounds_reg - 1'b1);
                    if (rounds_reg == round_t'(1))
                    begin
                        k_next     = '0;
                        fwd_next   = 1'b0;
                        state_next = ST_EMIT;
                    end
                end
            end

            // read the block out in order, one word per free result slot
            ST_EMIT:
            begin
                if (issue_ok)
                begin
                    ram_raddr      = k_reg;
                    pend_next      = 1'b1;
                    pend_last_next = (k_reg == last_addr);
                    k_next         = addr_t'(k_reg + 1'b1);
                    if (k_reg == last_addr)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            mode_reg      <= 1'b0;
            rounds_reg    <= '0;
            p_reg         <= '0;
            f_reg         <= '0;
            fwd_reg       <= 1'b0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            rounds_reg    <= rounds_next;
            p_reg         <= p_next;
            f_reg         <= f_next;
            fwd_reg       <= fwd_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath words
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        sum_reg       <= sum_next;
        z_reg         <= z_next;
        y_reg         <= y_next;
        cur_reg       <= cur_next;
        pend_last_reg <= pend_last_next;
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
    end

endmodule

FILE: hdl/xbc_checker.sv
// port-level checker for the xxtea block cipher unit, bound to the top level
// depends on xbc_pkg and xxtea_block_cipher_unit_defines.svh
`timescale 1ns / 1ps
`include "xxtea_block_cipher_unit_defines.svh"

module xbc_checker import xbc_pkg::*; (
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  in_block_end,
    input logic  out_valid,
    input logic  out_ready,
    input word_t result_word,
    input logic  result_last
);

    // a stalled result stays put
    `XBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result_word) && $stable(result_last), "result changed while stalled")

    // the transfer that ends a block stops loading
    `XBC_ASSERT_NEXT(a_end_stops_load, clk, rst_n, in_valid && in_ready && in_block_end, !in_ready, "input still taken after block end")

    // no new block is taken while an inner result word waits
    `XBC_ASSERT_NOW(a_emit_blocks_load, clk, rst_n, out_valid && !result_last, !in_ready, "input taken during result readout")

endmodule

bind xxtea_block_cipher_unit xbc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (word_stream.valid),
    .in_ready     (word_stream.ready),
    .in_block_end (word_stream.block_end),
    .out_valid    (result_stream.valid),
    .out_ready    (result_stream.ready),
    .result_word  (result_stream.result_word),
    .result_last  (result_stream.result_last)
);
